// ===== sv/srf_pkg.sv =====
`default_nettype none

package srf_pkg;

  // Depth of the validity window and widths of the fixed fields.
  localparam int WINDOW     = 40;
  localparam int DIST_W     = 16;
  localparam int WEIGHT_W   = 9;
  localparam int COUNT_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int PROD_W     = DIST_W + WEIGHT_W;
  localparam int ACC_W      = PROD_W + 1;
  localparam int FRAC_W     = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEW_WEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OLD_WEIGHT   = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [DIST_W-1:0]   MAX_DISTANCE_RST = 16'd3500;
  localparam logic [WEIGHT_W-1:0] NEW_WEIGHT_RST   = 9'd102;
  localparam logic [WEIGHT_W-1:0] OLD_WEIGHT_RST   = 9'd154;

  // The newer half of the window starts out full of ones.
  localparam logic [COUNT_W-1:0] COUNT_RST = COUNT_W'(WINDOW - WINDOW / 2);

  typedef struct packed {
    logic [DIST_W-1:0]   max_distance;
    logic [WEIGHT_W-1:0] new_weight;
    logic [WEIGHT_W-1:0] old_weight;
  } cfg_t;

endpackage

`default_nettype wire

// ===== sv/srf_cell.sv =====
`default_nettype none

module srf_cell
  import srf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic shift,
  input  wire logic init_flag,
  input  wire logic flag_in,
  output logic      flag
);

  // One slot of the validity window; takes its neighbor's flag on a shift.
  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= init_flag;
    end else if (shift) begin
      flag <= flag_in;
    end
  end

endmodule

`default_nettype wire

// ===== sv/srf_window.sv =====
`default_nettype none

module srf_window
  import srf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               shift,
  input  wire logic               flag_new,
  output logic [COUNT_W-1:0]      count_next
);

  // Slot 0 holds the oldest flag; new flags enter at the top slot.
  logic [WINDOW-1:0]  flags;
  logic [WINDOW-1:0]  feed;
  logic [COUNT_W-1:0] count;

  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    if (k == WINDOW - 1) begin : g_top
      assign feed[k] = flag_new;
    end else begin : g_mid
      assign feed[k] = flags[k + 1];
    end
    srf_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (shift),
      .init_flag ((k < WINDOW / 2) ? 1'b0 : 1'b1),
      .flag_in   (feed[k]),
      .flag      (flags[k])
    );
  end

  assign count_next = count - COUNT_W'(flags[0]) + COUNT_W'(flag_new);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= COUNT_RST;
    end else if (shift) begin
      count <= count_next;
    end
  end

`ifndef SYNTHESIS
  a_count_matches : assert property (@(posedge clk) disable iff (rst)
    COUNT_W'($countones(flags)) == count)
    else $error("running count differs from the ones in the window");

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(WINDOW))
    else $error("running count exceeds the window depth");
`endif

endmodule

`default_nettype wire

// ===== sv/srf_ema.sv =====
`default_nettype none

module srf_ema
  import srf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              update,
  input  wire cfg_t              cfg,
  input  wire logic [DIST_W-1:0] reading,
  input  wire logic              timed_out,
  output logic [DIST_W-1:0]      avg_next,
  output logic                   reading_ok
);

  logic [DIST_W-1:0] average;
  logic [PROD_W-1:0] prod_new;
  logic [PROD_W-1:0] prod_old;
  logic [ACC_W-1:0]  acc;
  logic [ACC_W-FRAC_W-1:0] blend;
  logic [DIST_W-1:0] blend_sat;

  assign reading_ok = !timed_out && (reading != '0) && (reading < cfg.max_distance);

  assign prod_new  = PROD_W'(cfg.new_weight) * PROD_W'(reading);
  assign prod_old  = PROD_W'(cfg.old_weight) * PROD_W'(average);
  assign acc       = ACC_W'(prod_new) + ACC_W'(prod_old);
  assign blend     = acc[ACC_W-1:FRAC_W];
  // Weights summing above one can push the blend past 16 bits.
  assign blend_sat = (|blend[ACC_W-FRAC_W-1:DIST_W]) ? '1 : blend[DIST_W-1:0];

  always_comb begin
    if (!reading_ok) begin
      avg_next = '0;
    end else if (average == '0) begin
      avg_next = reading;
    end else begin
      avg_next = blend_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      average <= '0;
    end else if (update) begin
      average <= avg_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sonar_reading_filter.sv =====
`default_nettype none

// Channel  | Direction | Handshake                  | Payload
// item     | in        | item_valid / item_stall    | high_byte, low_byte, timed_out
// result   | out       | result_valid / result_stall| avg_distance, distance_valid, valid_count
// cfg      | in        | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// An item is processed in the cycle it is accepted: the average, the window and the
// output register all load at the accepting edge, so the result is offered next cycle.
// One item per clock is sustained while the output register is empty or being taken.
// The path that sets the cycle is the 9 x 16 multiply-add of the moving average.
// Reset clears the average, sets the window to half zeros and half ones, and loads
// the register defaults. The item channel stalls only while a result is held stalled.

module sonar_reading_filter
  import srf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Item channel.
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  wire logic [7:0]           high_byte,
  input  wire logic [7:0]           low_byte,
  input  wire logic                 timed_out,
  // Result channel.
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output logic [DIST_W-1:0]         avg_distance,
  output logic                      distance_valid,
  output logic [COUNT_W-1:0]        valid_count,
  // Configuration channel.
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIST_W-1:0]    cfg_data
);

  cfg_t              cfg;
  logic              accept;
  logic [DIST_W-1:0] reading;
  logic [DIST_W-1:0] avg_next;
  logic              reading_ok;
  logic [COUNT_W-1:0] count_next;

  // Configuration writes are always accepted; the channel never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_distance <= MAX_DISTANCE_RST;
      cfg.new_weight   <= NEW_WEIGHT_RST;
      cfg.old_weight   <= OLD_WEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAX_DISTANCE: cfg.max_distance <= cfg_data;
        REG_NEW_WEIGHT:   cfg.new_weight   <= cfg_data[WEIGHT_W-1:0];
        REG_OLD_WEIGHT:   cfg.old_weight   <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // The output register can take a new result when it is empty or being drained.
  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;
  assign reading    = {high_byte, low_byte};

  srf_ema u_ema (
    .clk        (clk),
    .rst        (rst),
    .update     (accept),
    .cfg        (cfg),
    .reading    (reading),
    .timed_out  (timed_out),
    .avg_next   (avg_next),
    .reading_ok (reading_ok)
  );

  srf_window u_window (
    .clk        (clk),
    .rst        (rst),
    .shift      (accept),
    .flag_new   (reading_ok),
    .count_next (count_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Result payload needs no reset; it is qualified by result_valid.
  always_ff @(posedge clk) begin
    if (accept) begin
      avg_distance   <= avg_next;
      distance_valid <= reading_ok;
      valid_count    <= count_next;
    end
  end

`ifndef SYNTHESIS
  a_invalid_is_zero : assert property (@(posedge clk) disable iff (rst)
    result_valid && !distance_valid |-> avg_distance == '0)
    else $error("an invalid reading left a nonzero average");

  a_accept_fills : assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> result_valid)
    else $error("an accepted item produced no result");

  a_no_stall_when_empty : assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !item_stall)
    else $error("item channel stalled with an empty output register");
`endif

endmodule

`default_nettype wire

// ===== dv/sonar_reading_filter_tb.sv =====
`default_nettype none

module sonar_reading_filter_tb;
  import srf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // A run is ended when this many cycles pass with no transfer on any channel.
  localparam int QUIET_LIMIT = 2000;

  // Register index that maps to no register.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] hi;
    logic [7:0] lo;
    logic       to;
  } reply_t;

  typedef struct packed {
    logic [DIST_W-1:0]  avg;
    logic               ok;
    logic [COUNT_W-1:0] cnt;
  } filtered_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 item_valid = 1'b0;
  logic                 item_stall;
  logic [7:0]           high_byte = '0;
  logic [7:0]           low_byte = '0;
  logic                 timed_out = 1'b0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic [DIST_W-1:0]    avg_distance;
  logic                 distance_valid;
  logic [COUNT_W-1:0]   valid_count;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIST_W-1:0]    cfg_data = '0;

  sonar_reading_filter u_top (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .high_byte      (high_byte),
    .low_byte       (low_byte),
    .timed_out      (timed_out),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .avg_distance   (avg_distance),
    .distance_valid (distance_valid),
    .valid_count    (valid_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Replies waiting to be driven, and filter outputs waiting to be seen.
  reply_t    pending_replies[$];
  filtered_t expected_outputs[$];
  reply_t    next_reply;
  filtered_t oldest_output;

  // Idling knobs in percent, changed only between phases.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int          fails = 0;
  int          quiet_cycles = 0;

  // Our own copy of the filter state and of its registers.
  logic [DIST_W-1:0]   ema_avg;
  logic [WINDOW-1:0]   flag_window;  // bit 0 is the oldest flag
  logic [COUNT_W-1:0]  flag_count;
  logic [DIST_W-1:0]   lim_max;
  logic [WEIGHT_W-1:0] w_new;
  logic [WEIGHT_W-1:0] w_old;

  // Distance limit the stimulus generator aims at in the current phase.
  logic [DIST_W-1:0]   gen_max;

  function automatic void restore_filter();
    ema_avg = '0;
    for (int k = 0; k < WINDOW; k++) begin
      flag_window[k] = (k >= WINDOW / 2);
    end
    flag_count = COUNT_W'(WINDOW - WINDOW / 2);
    lim_max = MAX_DISTANCE_RST;
    w_new = NEW_WEIGHT_RST;
    w_old = OLD_WEIGHT_RST;
  endfunction

  // Advance the filter by one sensor reply and return what it should report.
  function automatic filtered_t ema_update(logic [7:0] hi, logic [7:0] lo, logic to);
    logic [DIST_W-1:0] reading;
    logic [ACC_W-1:0]  acc;
    logic              ok;
    filtered_t         res;
    reading = {hi, lo};
    ok = !to && (reading != '0) && (reading < lim_max);
    if (ok) begin
      if (ema_avg == '0) begin
        // An empty average is seeded by the reading itself.
        ema_avg = reading;
      end else begin
        acc = ACC_W'(w_new) * ACC_W'(reading) + ACC_W'(w_old) * ACC_W'(ema_avg);
        acc = acc >> FRAC_W;
        // Weights summing above one in Q8 can push the blend past 16 bits.
        ema_avg = (acc > ACC_W'(16'hFFFF)) ? 16'hFFFF : acc[DIST_W-1:0];
      end
    end else begin
      ema_avg = '0;
    end
    flag_count = flag_count - COUNT_W'(flag_window[0]);
    flag_window = flag_window >> 1;
    flag_window[WINDOW-1] = ok;
    flag_count = flag_count + COUNT_W'(ok);
    res.avg = ema_avg;
    res.ok = ok;
    res.cnt = flag_count;
    return res;
  endfunction

  // Driver: on every transfer the expected output is computed from the
  // payload on the ports, then the next reply goes out unless this cycle idles.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        expected_outputs.push_back(ema_update(high_byte, low_byte, timed_out));
      end
      if (!item_valid || !item_stall) begin
        if (pending_replies.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_reply = pending_replies.pop_front();
          item_valid <= 1'b1;
          high_byte <= next_reply.hi;
          low_byte <= next_reply.lo;
          timed_out <= next_reply.to;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: each result transfer is compared with the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_outputs.size() == 0) begin
          $error("result transfer with nothing expected: avg_distance %0d", avg_distance);
          fails++;
        end else begin
          oldest_output = expected_outputs.pop_front();
          if (avg_distance !== oldest_output.avg) begin
            $error("avg_distance: expected %0d, got %0d", oldest_output.avg, avg_distance);
            fails++;
          end
          if (distance_valid !== oldest_output.ok) begin
            $error("distance_valid: expected %0d, got %0d", oldest_output.ok,
                   distance_valid);
            fails++;
          end
          if (valid_count !== oldest_output.cnt) begin
            $error("valid_count: expected %0d, got %0d", oldest_output.cnt, valid_count);
            fails++;
          end
        end
      end
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: a run that stops making progress is a failure.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[sonar_reading_filter] ERROR");
        $finish;
      end
    end
  end

  function automatic void add_reply(logic [7:0] hi, logic [7:0] lo, logic to);
    reply_t r;
    r.hi = hi;
    r.lo = lo;
    r.to = to;
    pending_replies.push_back(r);
  endfunction

  // One random reply: valid with the given chance, otherwise one of the ways
  // a reading goes bad (timeout, zero, at or past the limit, or anything).
  function automatic void add_random_reply(int unsigned pct);
    logic [DIST_W-1:0] d;
    logic              to;
    if ($urandom_range(99) < pct && gen_max > 1) begin
      case ($urandom_range(9))
        0:       d = 16'd1;
        1:       d = gen_max - 16'd1;
        default: d = 16'($urandom_range(gen_max - 1, 1));
      endcase
      to = 1'b0;
    end else begin
      case ($urandom_range(3))
        0: begin
          d = 16'($urandom);
          to = 1'b1;
        end
        1: begin
          d = '0;
          to = 1'b0;
        end
        2: begin
          d = 16'($urandom_range(65535, gen_max));
          to = 1'b0;
        end
        default: begin
          d = 16'($urandom);
          to = 1'($urandom_range(1));
        end
      endcase
    end
    add_reply(d[15:8], d[7:0], to);
  endfunction

  // Wait until every reply has gone out and every output has come back,
  // then let the block settle so it is truly at rest.
  task automatic drain();
    do @(posedge clk);
    while (pending_replies.size() != 0 || item_valid || expected_outputs.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Register write over the configuration channel; only called while drained.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIST_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    case (idx)
      REG_MAX_DISTANCE: lim_max = data;
      REG_NEW_WEIGHT:   w_new = data[WEIGHT_W-1:0];
      REG_OLD_WEIGHT:   w_old = data[WEIGHT_W-1:0];
      default:          ;  // unknown index, the block must ignore it
    endcase
    @(posedge clk);
  endtask

  task automatic set_filter(logic [DIST_W-1:0] lim, logic [DIST_W-1:0] wn,
                            logic [DIST_W-1:0] wo);
    write_reg(REG_MAX_DISTANCE, lim);
    write_reg(REG_NEW_WEIGHT, wn);
    write_reg(REG_OLD_WEIGHT, wo);
    gen_max = lim;
  endtask

  // Random replies in bursts, each burst with its own share of good readings,
  // so the validity window swings between empty, full and in between.
  task automatic random_phase(int unsigned n);
    int unsigned burst;
    int unsigned pct;
    int unsigned queued;
    queued = 0;
    while (queued < n) begin
      burst = $urandom_range(60, 10);
      case ($urandom_range(3))
        0:       pct = 5;
        1:       pct = 40;
        2:       pct = 85;
        default: pct = 100;
      endcase
      for (int unsigned i = 0; i < burst && queued < n; i++) begin
        add_random_reply(pct);
        queued++;
      end
    end
  endtask

  initial begin
    logic [DIST_W-1:0] wn;
    restore_filter();
    gen_max = MAX_DISTANCE_RST;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default registers straight out of reset: zero distance, seeding, the largest
    // good reading, readings at and past the limit, timeouts (one whose bytes would
    // otherwise make a good reading), and a reseed followed by a blend.
    add_reply(8'h00, 8'h00, 1'b0);
    add_reply(8'h00, 8'h01, 1'b0);
    add_reply(8'h0D, 8'hAB, 1'b0);
    add_reply(8'h0D, 8'hAC, 1'b0);
    add_reply(8'hFF, 8'hFF, 1'b0);
    add_reply(8'h0D, 8'hAB, 1'b1);
    add_reply(8'hFF, 8'hFF, 1'b1);
    add_reply(8'h00, 8'h00, 1'b1);
    add_reply(8'h03, 8'hE8, 1'b0);
    add_reply(8'h07, 8'hD0, 1'b0);
    drain();

    // Widest limit and the largest weights, so the blend saturates. A write
    // to the unused index must leave the limit alone.
    set_filter(16'hFFFF, 16'd511, 16'd511);
    write_reg(REG_UNUSED, 16'h0001);
    add_reply(8'hFF, 8'hFE, 1'b0);
    add_reply(8'hFF, 8'hFE, 1'b0);
    add_reply(8'h9C, 8'h40, 1'b0);
    add_reply(8'hFF, 8'hFF, 1'b0);
    drain();

    // Zero weights: a good reading blends to zero and the next one reseeds.
    set_filter(16'hFFFF, 16'd0, 16'd0);
    add_reply(8'h00, 8'h05, 1'b0);
    add_reply(8'h00, 8'h06, 1'b0);
    add_reply(8'h00, 8'h07, 1'b0);
    drain();

    // A zero limit and a limit of one both reject everything.
    set_filter(16'd0, 16'd102, 16'd154);
    add_reply(8'h00, 8'h01, 1'b0);
    add_reply(8'h80, 8'h00, 1'b0);
    drain();
    set_filter(16'd1, 16'd102, 16'd154);
    add_reply(8'h00, 8'h01, 1'b0);
    add_reply(8'h00, 8'h00, 1'b0);
    drain();

    // Random phases, each with its own registers; the idling pattern repeats every four phases.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_filter(16'd3500, 16'd102, 16'd154);
        1: set_filter(16'hFFFF, 16'd256, 16'd0);
        2: set_filter(16'd40000, 16'd0, 16'd256);
        3: set_filter(16'd1200, 16'd200, 16'd200);
        4: set_filter(16'hFFFF, 16'd511, 16'd511);
        default: begin
          wn = 16'($urandom_range(256));
          set_filter(16'($urandom_range(65535, 1)), wn, 16'd256 - wn);
        end
      endcase
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 60;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 60;
        end
        default: begin
          send_idle_pct = 8;
          stall_pct = 8;
        end
      endcase
      random_phase(175);
      drain();
      send_idle_pct = 0;
      stall_pct = 0;
    end

    drain();
    if (fails == 0 && expected_outputs.size() == 0) begin
      $display("[sonar_reading_filter] OK");
    end else begin
      $display("[sonar_reading_filter] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
